// ===== rtl/core/dcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg: shared definitions for the distance constraint relaxation block
// Default sizes and the pipeline control bundle handed to every stage module.
// ----------------------------------------------------------------------------
package dcr_pkg;

    // default coordinate width (signed Q12.8)
    localparam int COORD_BITS_DEF = 20;

    // per-stage control: advance enable and valid entering the unit
    typedef struct packed {
        logic en;
        logic vld;
    } stage_ctl_t;

endpackage

// ===== rtl/core/dcr_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_sqrt_pipe: pipelined integer square root
// One result bit per stage (digit-by-digit method), floor(sqrt(radicand)).
// Side-band bits travel alongside each item.
// ----------------------------------------------------------------------------
module dcr_sqrt_pipe #(
    parameter int RW  = 21,
    parameter int SBW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dcr_pkg::stage_ctl_t   ctl,
    input  logic [2*RW-1:0]       radicand,
    input  logic [SBW-1:0]        sb_in,
    output logic                  out_vld,
    output logic [RW-1:0]         root,
    output logic [SBW-1:0]        sb_out
);

    logic              vld_reg  [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [2*RW-1:0]   rad_reg  [RW];
    logic [SBW-1:0]    sb_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int I = RW - 1 - k;

        logic              v_in;
        logic [RW+1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [2*RW-1:0]   rad_in;
        logic [SBW-1:0]    sb_i;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = ctl.vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign sb_i    = sb_in;
        end else begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign sb_i    = sb_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_in[RW-1:0], rad_in[2*I+1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctl.en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[RW-2:0], take};
                rad_reg[k]  <= rad_in;
                sb_reg[k]   <= sb_i;
            end
        end
    end

    assign out_vld = vld_reg[RW-1];
    assign root    = root_reg[RW-1];
    assign sb_out  = sb_reg[RW-1];

endmodule

// ===== rtl/core/dcr_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_div_pipe: pipelined restoring divider
// One quotient bit per stage. The numerator must be below divisor << QW.
// Side-band bits travel alongside each item.
// ----------------------------------------------------------------------------
module dcr_div_pipe #(
    parameter int DW  = 22,
    parameter int QW  = 21,
    parameter int SBW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dcr_pkg::stage_ctl_t   ctl,
    input  logic [DW+QW-1:0]      numer,
    input  logic [DW-1:0]         denom,
    input  logic [SBW-1:0]        sb_in,
    output logic                  out_vld,
    output logic [QW-1:0]         quot,
    output logic [SBW-1:0]        sb_out
);

    localparam int TW = DW + QW;

    logic              vld_reg [QW];
    logic [TW-1:0]     rem_reg [QW];
    logic [DW-1:0]     den_reg [QW];
    logic [QW-1:0]     q_reg   [QW];
    logic [SBW-1:0]    sb_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int I = QW - 1 - k;

        logic           v_in;
        logic [TW-1:0]  rem_in;
        logic [DW-1:0]  den_in;
        logic [QW-1:0]  q_in;
        logic [SBW-1:0] sb_i;
        logic [TW-1:0]  shifted;
        logic           take;

        if (k == 0) begin : g_first
            assign v_in   = ctl.vld;
            assign rem_in = numer;
            assign den_in = denom;
            assign q_in   = '0;
            assign sb_i   = sb_in;
        end else begin : g_next
            assign v_in   = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign sb_i   = sb_reg[k-1];
        end

        // compare against divisor aligned to this quotient bit
        assign shifted = TW'(den_in) << I;
        assign take    = (rem_in >= shifted);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctl.en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                rem_reg[k] <= take ? (rem_in - shifted) : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (QW'(take) << I);
                sb_reg[k]  <= sb_i;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quot    = q_reg[QW-1];
    assign sb_out  = sb_reg[QW-1];

endmodule

// ===== rtl/core/distance_constraint_relax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_constraint_relax: Verlet stick constraint relaxation
// Moves unpinned ends along the stick by (rest - d) / (2d) of the difference,
// with d = floor(sqrt(dx^2 + dy^2)); saturated signed results.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | first/second x,y, fixed flags, rest
//   m_      | out | m_valid / m_ready  | new first/second x,y, coincident
//
// One item per cycle while m_ready does not stall. The square root and
// divider pipelines each resolve one result bit per stage.
// Synchronous active-low reset clears all valid bits.
// A stall on m_ready freezes the whole pipeline; s_ready drops with it.
// ----------------------------------------------------------------------------
module distance_constraint_relax #(
    parameter int COORD_BITS = dcr_pkg::COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_first_x,
    input  logic [COORD_BITS-1:0] s_first_y,
    input  logic [COORD_BITS-1:0] s_second_x,
    input  logic [COORD_BITS-1:0] s_second_y,
    input  logic                  s_first_fixed,
    input  logic                  s_second_fixed,
    input  logic [COORD_BITS-1:0] s_rest_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_new_first_x,
    output logic [COORD_BITS-1:0] m_new_first_y,
    output logic [COORD_BITS-1:0] m_new_second_x,
    output logic [COORD_BITS-1:0] m_new_second_y,
    output logic                  m_coincident
);

    localparam int CW   = COORD_BITS;
    localparam int MW   = CW + 1;        // |dx|, d, |rest - d|
    localparam int SW   = 2 * MW;        // sum of squares
    localparam int DW   = MW + 1;        // divisor 2d
    localparam int QW   = MW;            // offset magnitude
    localparam int TW   = DW + QW;       // numerator
    localparam int SB1W = 5 * CW + 4 + 2 * MW;
    localparam int SB2W = 4 * CW + 4;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // saturate a wide signed value to the coordinate range
    function automatic logic [CW-1:0] sat_coord(input logic [MW+1:0] v);
        logic [CW-1:0] r;
        if (!v[MW+1] && (v[MW:CW-1] != '0)) begin
            r = {1'b0, {(CW-1){1'b1}}};
        end else if (v[MW+1] && (v[MW:CW-1] != '1)) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // ---------------- stage 1: differences and magnitudes ----------------
    logic [MW-1:0] dx_c, dy_c, adx_c, ady_c;
    assign dx_c  = {s_second_x[CW-1], s_second_x} - {s_first_x[CW-1], s_first_x};
    assign dy_c  = {s_second_y[CW-1], s_second_y} - {s_first_y[CW-1], s_first_y};
    assign adx_c = dx_c[MW-1] ? (~dx_c + MW'(1)) : dx_c;
    assign ady_c = dy_c[MW-1] ? (~dy_c + MW'(1)) : dy_c;

    logic          v1_reg;
    logic [CW-1:0] x0_1_reg, y0_1_reg, x1_1_reg, y1_1_reg, rest_1_reg;
    logic          p0_1_reg, p1_1_reg, sx_1_reg, sy_1_reg;
    logic [MW-1:0] adx_1_reg, ady_1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_1_reg   <= s_first_x;
            y0_1_reg   <= s_first_y;
            x1_1_reg   <= s_second_x;
            y1_1_reg   <= s_second_y;
            rest_1_reg <= s_rest_length;
            p0_1_reg   <= s_first_fixed;
            p1_1_reg   <= s_second_fixed;
            sx_1_reg   <= dx_c[MW-1];
            sy_1_reg   <= dy_c[MW-1];
            adx_1_reg  <= adx_c;
            ady_1_reg  <= ady_c;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [SW-1:0] sqx_c, sqy_c;
    assign sqx_c = adx_1_reg * adx_1_reg;
    assign sqy_c = ady_1_reg * ady_1_reg;

    logic          v2_reg;
    logic [SW-1:0] sqx_2_reg, sqy_2_reg;
    logic [SB1W-1:0] sb_2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_2_reg <= sqx_c;
            sqy_2_reg <= sqy_c;
            sb_2_reg  <= {x0_1_reg, y0_1_reg, x1_1_reg, y1_1_reg, rest_1_reg,
                          p0_1_reg, p1_1_reg, sx_1_reg, sy_1_reg,
                          adx_1_reg, ady_1_reg};
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic            v3_reg;
    logic [SW-1:0]   sum_3_reg;
    logic [SB1W-1:0] sb_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_3_reg <= sqx_2_reg + sqy_2_reg;
            sb_3_reg  <= sb_2_reg;
        end
    end

    // ---------------- square root ----------------
    logic            vq;
    logic [MW-1:0]   d_q;
    logic [SB1W-1:0] sb_q;

    dcr_sqrt_pipe #(
        .RW  (MW),
        .SBW (SB1W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      ('{en: en, vld: v3_reg}),
        .radicand (sum_3_reg),
        .sb_in    (sb_3_reg),
        .out_vld  (vq),
        .root     (d_q),
        .sb_out   (sb_q)
    );

    logic [CW-1:0] x0_q, y0_q, x1_q, y1_q, rest_q;
    logic          p0_q, p1_q, sx_q, sy_q;
    logic [MW-1:0] adx_q, ady_q;
    assign {x0_q, y0_q, x1_q, y1_q, rest_q, p0_q, p1_q, sx_q, sy_q, adx_q, ady_q} = sb_q;

    // ---------------- stage 4: rest - d ----------------
    logic [MW:0] diff_c, ndiff_c;
    assign diff_c  = {2'b00, rest_q} - {1'b0, d_q};
    assign ndiff_c = ~diff_c + (MW+1)'(1);

    logic            v4_reg;
    logic [MW-1:0]   d_4_reg, dmag_4_reg, adx_4_reg, ady_4_reg;
    logic            dneg_4_reg, coin_4_reg, sx_4_reg, sy_4_reg;
    logic [SB2W-3:0] pos_4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_4_reg    <= d_q;
            dneg_4_reg <= diff_c[MW];
            dmag_4_reg <= diff_c[MW] ? ndiff_c[MW-1:0] : diff_c[MW-1:0];
            coin_4_reg <= (d_q == '0);
            adx_4_reg  <= adx_q;
            ady_4_reg  <= ady_q;
            sx_4_reg   <= sx_q;
            sy_4_reg   <= sy_q;
            pos_4_reg  <= {x0_q, y0_q, x1_q, y1_q, p0_q, p1_q};
        end
    end

    // ---------------- stage 5: numerators and divisor ----------------
    logic [TW-2:0] prx_c, pry_c;
    assign prx_c = adx_4_reg * dmag_4_reg;
    assign pry_c = ady_4_reg * dmag_4_reg;

    logic            v5_reg;
    logic [TW-1:0]   numx_5_reg, numy_5_reg;
    logic [DW-1:0]   den_5_reg;
    logic            negx_5_reg, negy_5_reg;
    logic [SB2W-1:0] sb_5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numx_5_reg <= {1'b0, prx_c} + TW'(d_4_reg);
            numy_5_reg <= {1'b0, pry_c} + TW'(d_4_reg);
            den_5_reg  <= {d_4_reg, 1'b0};
            negx_5_reg <= sx_4_reg ^ dneg_4_reg;
            negy_5_reg <= sy_4_reg ^ dneg_4_reg;
            sb_5_reg   <= {pos_4_reg, coin_4_reg, sx_4_reg ^ dneg_4_reg};
        end
    end

    // ---------------- dividers, one per axis ----------------
    logic            vdx, vdy;
    logic [QW-1:0]   qx, qy;
    logic [SB2W-1:0] sb_dx;
    logic            negy_d;

    dcr_div_pipe #(
        .DW  (DW),
        .QW  (QW),
        .SBW (SB2W)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     ('{en: en, vld: v5_reg}),
        .numer   (numx_5_reg),
        .denom   (den_5_reg),
        .sb_in   (sb_5_reg),
        .out_vld (vdx),
        .quot    (qx),
        .sb_out  (sb_dx)
    );

    dcr_div_pipe #(
        .DW  (DW),
        .QW  (QW),
        .SBW (1)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     ('{en: en, vld: v5_reg}),
        .numer   (numy_5_reg),
        .denom   (den_5_reg),
        .sb_in   (negy_5_reg),
        .out_vld (vdy),
        .quot    (qy),
        .sb_out  (negy_d)
    );

    logic [CW-1:0] x0_d, y0_d, x1_d, y1_d;
    logic          p0_d, p1_d, coin_d, negx_d;
    assign {x0_d, y0_d, x1_d, y1_d, p0_d, p1_d, coin_d, negx_d} = sb_dx;

    // ---------------- stage 6: apply offsets, saturate ----------------
    logic [MW+1:0] oxe, oye, oxs, oys;
    logic [MW+1:0] x0e, y0e, x1e, y1e;
    assign oxe = {2'b00, qx};
    assign oye = {2'b00, qy};
    assign oxs = negx_d ? (~oxe + (MW+2)'(1)) : oxe;
    assign oys = negy_d ? (~oye + (MW+2)'(1)) : oye;
    assign x0e = {{3{x0_d[CW-1]}}, x0_d};
    assign y0e = {{3{y0_d[CW-1]}}, y0_d};
    assign x1e = {{3{x1_d[CW-1]}}, x1_d};
    assign y1e = {{3{y1_d[CW-1]}}, y1_d};

    logic          m_valid_reg;
    logic [CW-1:0] nx0_reg, ny0_reg, nx1_reg, ny1_reg;
    logic          coin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vdx & vdy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coin_reg <= coin_d;
            nx0_reg  <= (coin_d || p0_d) ? x0_d : sat_coord(x0e - oxs);
            ny0_reg  <= (coin_d || p0_d) ? y0_d : sat_coord(y0e - oys);
            nx1_reg  <= (coin_d || p1_d) ? x1_d : sat_coord(x1e + oxs);
            ny1_reg  <= (coin_d || p1_d) ? y1_d : sat_coord(y1e + oys);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_new_first_x  = nx0_reg;
    assign m_new_first_y  = ny0_reg;
    assign m_new_second_x = nx1_reg;
    assign m_new_second_y = ny1_reg;
    assign m_coincident   = coin_reg;

endmodule
